// ===== design/trle_pkg.sv =====
// Shared types and constants for the transparent run-length encoder.
`default_nettype none

package trle_pkg;

    localparam int MAX_RUN_DEFAULT    = 63;
    localparam int PIXEL_BITS_DEFAULT = 32;
    localparam int COUNT_BITS         = 8;
    localparam int PIXEL_FIELD_BITS   = 32;
    localparam int QUEUE_DEPTH        = 4;

    typedef logic [COUNT_BITS-1:0] count_t;

    // One queued segment command: what the back end has to emit for one word.
    typedef struct packed {
        logic   flush;      // code plus buffered literals
        logic   cap;        // capped empty run code
        logic   endc;       // row-end code
        logic   bank;       // literal buffer bank of the flushed segment
        count_t empty;
        count_t filled;
        count_t end_empty;
    } seg_cmd_t;

    // Back end reports a bank fully replayed.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_done_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CODE,
        BK_LIT,
        BK_CAP,
        BK_END
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/trle_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module trle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/trle_fifo.sv =====
// Small command queue between front and back end.
`default_nettype none

module trle_fifo #(
    parameter int DEPTH = trle_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire trle_pkg::seg_cmd_t din,
    input  wire logic              pop,
    output trle_pkg::seg_cmd_t     dout,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trle_pkg::seg_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rptr_reg];
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== design/trle_front.sv =====
// Front end: run tracking, literal buffering and segment command issue.
`default_nettype none

module trle_front #(
    parameter int MAX_RUN = trle_pkg::MAX_RUN_DEFAULT,
    parameter int STORE_W = trle_pkg::PIXEL_FIELD_BITS,
    parameter int IDX_W   = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [STORE_W-1:0]    in_pixel,
    input  wire logic                  in_transp,
    input  wire logic                  in_rend,
    output trle_pkg::seg_cmd_t         cmd,
    output logic                       cmd_push,
    input  wire logic                  cmd_full,
    input  wire trle_pkg::bank_done_t  done,
    output logic                       buf_we,
    output logic [IDX_W:0]             buf_waddr,
    output logic [STORE_W-1:0]         buf_wdata
);

    localparam trle_pkg::count_t MAX_CNT = trle_pkg::COUNT_BITS'(MAX_RUN);

    logic             phase_reg, phase_next;
    trle_pkg::count_t empty_reg, empty_next;
    trle_pkg::count_t filled_reg, filled_next;
    logic             bank_reg, bank_next;
    logic [1:0]       pend_reg, pend_next;
    logic [1:0]       pend_set, pend_clr;
    logic             accept;
    logic             cap;
    trle_pkg::count_t e_new;
    trle_pkg::count_t f_new;

    // A bank still owed to the back end cannot take new literals.
    assign in_ready = !cmd_full && !pend_reg[bank_reg];
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next  = phase_reg;
        empty_next  = empty_reg;
        filled_next = filled_reg;
        bank_next   = bank_reg;
        pend_set    = '0;
        cmd         = '0;
        cmd_push    = 1'b0;
        buf_we      = 1'b0;
        buf_waddr   = {bank_reg, filled_reg[IDX_W-1:0]};
        buf_wdata   = in_pixel;
        cap         = !phase_reg && (empty_reg >= MAX_CNT);
        e_new       = ((phase_reg || cap) ? '0 : empty_reg) + 1'b1;
        f_new       = filled_reg + 1'b1;
        cmd.bank    = bank_reg;
        cmd.empty   = empty_reg;
        if (accept) begin
            if (in_transp) begin
                cmd.flush     = phase_reg;
                cmd.filled    = filled_reg;
                cmd.cap       = cap;
                cmd.endc      = in_rend;
                cmd.end_empty = e_new;
                cmd_push      = phase_reg || cap || in_rend;
                empty_next    = in_rend ? '0 : e_new;
                filled_next   = '0;
                phase_next    = 1'b0;
                if (phase_reg) begin
                    bank_next          = ~bank_reg;
                    pend_set[bank_reg] = 1'b1;
                end
            end else begin
                buf_we = 1'b1;
                if (f_new >= MAX_CNT || in_rend) begin
                    cmd.flush          = 1'b1;
                    cmd.filled         = f_new;
                    cmd_push           = 1'b1;
                    empty_next         = '0;
                    filled_next        = '0;
                    phase_next         = 1'b0;
                    bank_next          = ~bank_reg;
                    pend_set[bank_reg] = 1'b1;
                end else begin
                    filled_next = f_new;
                    phase_next  = 1'b1;
                end
            end
        end
        pend_clr            = '0;
        pend_clr[done.bank] = done.valid;
        pend_next           = (pend_reg & ~pend_clr) | pend_set;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            empty_reg  <= '0;
            filled_reg <= '0;
            bank_reg   <= 1'b0;
            pend_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            empty_reg  <= empty_next;
            filled_reg <= filled_next;
            bank_reg   <= bank_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/trle_back.sv =====
// Back end: replays queued segment commands as codes and literal words.
`default_nettype none

module trle_back #(
    parameter int STORE_W = trle_pkg::PIXEL_FIELD_BITS,
    parameter int IDX_W   = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_empty,
    input  wire trle_pkg::seg_cmd_t   cmd,
    output logic                      cmd_pop,
    output logic                      buf_re,
    output logic [IDX_W:0]            buf_raddr,
    input  wire logic [STORE_W-1:0]   buf_rdata,
    output trle_pkg::bank_done_t      done,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_code,
    output logic                      out_rowend,
    output trle_pkg::count_t          out_empty,
    output trle_pkg::count_t          out_filled,
    output logic [STORE_W-1:0]        out_pixel,
    output logic                      out_last
);

    trle_pkg::back_state_t state_reg, state_next;
    trle_pkg::seg_cmd_t    cur_reg, cur_next;
    trle_pkg::count_t      idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic                  code_reg, code_next;
    logic                  rowend_reg, rowend_next;
    trle_pkg::count_t      e_reg, e_next;
    trle_pkg::count_t      f_reg, f_next;
    logic [STORE_W-1:0]    pix_reg, pix_next;
    logic                  last_reg, last_next;
    logic                  out_free;

    assign out_free = !valid_reg || out_ready;

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !out_ready;
        code_next   = code_reg;
        rowend_next = rowend_reg;
        e_next      = e_reg;
        f_next      = f_reg;
        pix_next    = pix_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        buf_re      = 1'b0;
        buf_raddr   = {cur_reg.bank, idx_reg[IDX_W-1:0]};
        done        = '0;
        case (state_reg)
            trle_pkg::BK_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    if (cmd.flush) begin
                        state_next = trle_pkg::BK_CODE;
                    end else if (cmd.cap) begin
                        state_next = trle_pkg::BK_CAP;
                    end else begin
                        state_next = trle_pkg::BK_END;
                    end
                end
            end
            trle_pkg::BK_CODE: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    code_next   = 1'b1;
                    rowend_next = 1'b0;
                    e_next      = cur_reg.empty;
                    f_next      = cur_reg.filled;
                    pix_next    = '0;
                    last_next   = 1'b0;
                    // first literal fetched while the code goes out
                    buf_re      = 1'b1;
                    buf_raddr   = {cur_reg.bank, {IDX_W{1'b0}}};
                    idx_next    = '0;
                    state_next  = trle_pkg::BK_LIT;
                end
            end
            trle_pkg::BK_LIT: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    code_next   = 1'b0;
                    rowend_next = 1'b0;
                    e_next      = '0;
                    f_next      = '0;
                    pix_next    = buf_rdata;
                    if (idx_reg + 1'b1 < cur_reg.filled) begin
                        last_next = 1'b0;
                        idx_next  = idx_reg + 1'b1;
                        buf_re    = 1'b1;
                        buf_raddr = {cur_reg.bank, idx_next[IDX_W-1:0]};
                    end else begin
                        last_next  = !cur_reg.endc;
                        done.valid = 1'b1;
                        done.bank  = cur_reg.bank;
                        state_next = cur_reg.endc ? trle_pkg::BK_END : trle_pkg::BK_IDLE;
                    end
                end
            end
            trle_pkg::BK_CAP: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    code_next   = 1'b1;
                    rowend_next = 1'b0;
                    e_next      = cur_reg.empty;
                    f_next      = '0;
                    pix_next    = '0;
                    last_next   = !cur_reg.endc;
                    state_next  = cur_reg.endc ? trle_pkg::BK_END : trle_pkg::BK_IDLE;
                end
            end
            trle_pkg::BK_END: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    code_next   = 1'b1;
                    rowend_next = 1'b1;
                    e_next      = cur_reg.end_empty;
                    f_next      = '0;
                    pix_next    = '0;
                    last_next   = 1'b1;
                    state_next  = trle_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = trle_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trle_pkg::BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        code_reg   <= code_next;
        rowend_reg <= rowend_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        pix_reg    <= pix_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_code   = code_reg;
    assign out_rowend = rowend_reg;
    assign out_empty  = e_reg;
    assign out_filled = f_reg;
    assign out_pixel  = pix_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// ===== design/transparent_run_length_encoder.sv =====
// Top level of the transparent sprite run-length encoder.
//
// Sprite pixels enter in row order, one word per handshake, with the transparent
// flag on s_tuser and the last pixel of each row marked by s_tlast. Each row is
// cut into segments of up to MAX_RUN transparent pixels followed by up to MAX_RUN
// opaque pixels; each segment comes out as one length code followed by its opaque
// pixels as literal words. A row that ends on a transparent pixel gets a code with the
// row-end flag. m_tlast marks the last word caused by one input word.
// Rate: the front end takes one pixel per cycle while the command queue has room
// and the literal bank it writes is free; the back end loads each queued command
// in its idle state and then sends its result words, each once the output is free.
// Long runs cost the least per pixel; a stream of one-pixel opaque rows is the
// slowest, as each takes a load, a code and a literal. Literals sit in a two-bank
// buffer RAM, so one segment is replayed while the next is collected. No clearing
// pass after reset.
`default_nettype none

module transparent_run_length_encoder #(
    parameter int MAX_RUN    = trle_pkg::MAX_RUN_DEFAULT,
    parameter int PIXEL_BITS = trle_pkg::PIXEL_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel_value
    input  wire logic [0:0]  s_tuser,   // [0] is_transparent
    input  wire logic        s_tlast,   // row_end
    // encoded stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] empty_count, [15:8] filled_count,
                                        // [47:16] pixel_out
    output logic [1:0]       m_tuser,   // [0] is_length_code, [1] is_row_end
    output logic             m_tlast    // last_of_burst
);

    // only the low pixel bits that fit the field are kept
    localparam int STORE_W = (PIXEL_BITS < trle_pkg::PIXEL_FIELD_BITS) ?
                             PIXEL_BITS : trle_pkg::PIXEL_FIELD_BITS;
    localparam int IDX_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int RAM_D   = 2 ** (IDX_W + 1);

    trle_pkg::seg_cmd_t   cmd_in, cmd_out;
    logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
    trle_pkg::bank_done_t done;
    logic                 buf_we, buf_re;
    logic [IDX_W:0]       buf_waddr, buf_raddr;
    logic [STORE_W-1:0]   buf_wdata, buf_rdata;
    logic [STORE_W-1:0]   out_pixel;
    trle_pkg::count_t     out_empty, out_filled;
    logic                 out_code, out_rowend;

    trle_front #(
        .MAX_RUN (MAX_RUN),
        .STORE_W (STORE_W),
        .IDX_W   (IDX_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata[STORE_W-1:0]),
        .in_transp (s_tuser[0]),
        .in_rend   (s_tlast),
        .cmd       (cmd_in),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full),
        .done      (done),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata)
    );

    trle_fifo #(
        .DEPTH (trle_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .din     (cmd_in),
        .pop     (cmd_pop),
        .dout    (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // literal buffer: {bank, index}
    trle_ram #(
        .WIDTH (STORE_W),
        .DEPTH (RAM_D)
    ) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    trle_back #(
        .STORE_W (STORE_W),
        .IDX_W   (IDX_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_empty  (cmd_empty),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .buf_re     (buf_re),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata),
        .done       (done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_code   (out_code),
        .out_rowend (out_rowend),
        .out_empty  (out_empty),
        .out_filled (out_filled),
        .out_pixel  (out_pixel),
        .out_last   (m_tlast)
    );

    assign m_tdata = {trle_pkg::PIXEL_FIELD_BITS'(out_pixel), out_filled, out_empty};
    assign m_tuser = {out_rowend, out_code};

endmodule

`default_nettype wire

// ===== design/trle_checker.sv =====
// Port-level checks for the encoder, bound to the top level.
`default_nettype none

module trle_checker #(
    parameter int MAX_RUN = trle_pkg::MAX_RUN_DEFAULT
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    localparam logic [7:0] CAP = 8'(MAX_RUN);

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // literal words carry no counts and no row-end flag
    a_literal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0 && !m_tuser[1])
        else $error("literal word with code fields set");

    // row-end code has no filled pixels and closes the burst
    a_rowend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[15:8] == 8'd0 && m_tlast)
        else $error("malformed row-end code");

    // codes stay within the run cap and carry no pixel
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] <= CAP && m_tdata[15:8] <= CAP &&
                                   m_tdata[47:16] == 32'd0)
        else $error("length code out of range");

endmodule

bind transparent_run_length_encoder trle_checker #(.MAX_RUN(MAX_RUN)) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the transparent run-length encoder.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_RUN      = trle_pkg::MAX_RUN_DEFAULT;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 30;
    localparam int HOLD_CYCLES  = 300;    // long back-pressure stretch on the output
    localparam int DRAIN_CYCLES = 2 * (MAX_RUN + 1) + 16;
    localparam int LIMIT_CYCLES = 500000;

    // One encoded output word, fields as the block defines them.
    typedef struct packed {
        logic        is_code;
        logic        row_end;
        logic [7:0]  empty;
        logic [7:0]  filled;
        logic [31:0] pixel;
        logic        last;
    } rle_word_t;

    // Directed stimulus row: rep copies of one pixel kind, row end, where set, on the last copy.
    // A row with known set carries its single expected code word typed in.
    typedef struct packed {
        logic [7:0]  rep;
        logic [31:0] pix;
        logic        transp;
        logic        rend;
        logic        known;
        logic        k_end;
        logic [7:0]  k_empty;
    } dir_row_t;

    localparam int DIR_ROWS = 11;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // single transparent row right after reset: end code (1,0)
        '{8'd1,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 8'd1},
        // single opaque row, all-ones pixel
        '{8'd1,  32'hffff_ffff, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        // opaque then transparent: segment closes, new empty run starts
        '{8'd1,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd1,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd1,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 8'd2},
        // empty run at cap, then a filled run that hits the cap on the row end:
        // one plain segment, the longest burst
        '{8'd63, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd63, 32'ha5a5_a5a5, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        // opaque, transparent, opaque ending the row inside the opaque run
        '{8'd2,  32'h7fff_fffe, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd1,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd2,  32'h5555_5555, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        // lone transparent row end after a closed segment
        '{8'd1,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 8'd1}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] pixel_value
    logic [0:0]  s_tuser;     // [0] is_transparent
    logic        s_tlast;     // row_end
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // [7:0] empty_count, [15:8] filled_count, [47:16] pixel_out
    logic [1:0]  m_tuser;     // [0] is_length_code, [1] is_row_end
    logic        m_tlast;     // last_of_burst

    // predictor state
    logic        enc_filled_phase;
    logic [7:0]  enc_empty_run;
    logic [7:0]  enc_filled_run;
    logic [31:0] enc_opaque_buf [MAX_RUN];
    rle_word_t   burst_words[$];      // words caused by the word being encoded
    rle_word_t   pending_words[$];    // encoded words not yet seen on the output

    // run control and statistics
    logic        quiet;               // no idling on either side
    logic        hold_req;
    int          hold_left;
    int          stall_left;
    int          cycle_cnt;
    int          fail_cnt;
    int          words_sent;
    int          results_seen;
    int          codes_seen;
    int          end_codes_seen;
    int          literals_seen;
    int          longest_burst;
    int          input_stall_cycles;
    rle_word_t   want_w;
    rle_word_t   got_w;

    transparent_run_length_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // ---------------------------------------------------------------- predictor

    function automatic rle_word_t code_word(logic [7:0] e, logic [7:0] f, logic re);
        rle_word_t w;
        w = '0;
        w.is_code = 1'b1;
        w.row_end = re;
        w.empty   = e;
        w.filled  = f;
        return w;
    endfunction

    // Segment closes: its code, then the opaque pixels in arrival order.
    function automatic void close_segment();
        burst_words.push_back(code_word(enc_empty_run, enc_filled_run, 1'b0));
        for (int i = 0; i < enc_filled_run && i < MAX_RUN; i++) begin
            burst_words.push_back('{is_code: 1'b0, row_end: 1'b0, empty: 8'd0,
                                    filled: 8'd0, pixel: enc_opaque_buf[i], last: 1'b0});
        end
        enc_filled_phase = 1'b0;
        enc_empty_run    = 8'd0;
        enc_filled_run   = 8'd0;
    endfunction

    // Works out the words one accepted pixel causes, into burst_words.
    function automatic void encode_pixel(logic [31:0] pix, logic transp, logic rend);
        burst_words.delete();
        if (transp) begin
            if (enc_filled_phase)
                close_segment();
            if (enc_empty_run >= MAX_RUN) begin
                burst_words.push_back(code_word(enc_empty_run, 8'd0, 1'b0));
                enc_empty_run = 8'd0;
            end
            enc_empty_run++;
            if (rend) begin
                burst_words.push_back(code_word(enc_empty_run, 8'd0, 1'b1));
                enc_empty_run = 8'd0;
            end
        end else begin
            enc_filled_phase = 1'b1;
            if (enc_filled_run < MAX_RUN)
                enc_opaque_buf[enc_filled_run] = pix;
            enc_filled_run++;
            if (enc_filled_run >= MAX_RUN || rend)
                close_segment();
        end
        if (burst_words.size() > 0)
            burst_words[burst_words.size() - 1].last = 1'b1;
        if (burst_words.size() > longest_burst)
            longest_burst = burst_words.size();
    endfunction

    // ---------------------------------------------------------------- input side

    // Offers one word, optionally after a random gap, and books its results
    // once accepted. A known word replaces the predicted burst.
    task automatic drive_word(input logic [31:0] pix, input logic transp, input logic rend,
                              input logic known, input rle_word_t known_w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= transp;
        s_tlast  <= rend;
        do @(posedge aclk); while (!s_tready);
        encode_pixel(pix, transp, rend);
        if (known)
            pending_words.push_back(known_w);
        else
            foreach (burst_words[i]) pending_words.push_back(burst_words[i]);
        words_sent++;
    endtask

    // Sender stops until every booked word has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words.size() != 0);
    endtask

    // Mostly short runs, now and then one around the cap.
    function automatic int pick_run();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(MAX_RUN - 1, MAX_RUN + 2);
        return $urandom_range(0, 5);
    endfunction

    // One well-formed row: a few empty/filled segments, random pixels.
    task automatic send_random_row();
        logic kinds[$];
        int   nseg;
        int   e;
        int   f;
        nseg = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
            e = pick_run();
            f = pick_run();
            repeat (e) kinds.push_back(1'b1);
            repeat (f) kinds.push_back(1'b0);
        end
        if (kinds.size() == 0)
            kinds.push_back(1'b1);
        foreach (kinds[i])
            drive_word($urandom, kinds[i], i == kinds.size() - 1, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------- output side

    // Receiver: random stall bursts, plus one long hold on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("word %0d %s: expected 0x%0h, got 0x%0h", results_seen, name, want, got);
            fail_cnt++;
        end
    endtask

    // Output checker: every accepted word against the oldest booked one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
            if (m_tvalid && m_tready) begin
                got_w = '{is_code: m_tuser[0], row_end: m_tuser[1], empty: m_tdata[7:0],
                          filled: m_tdata[15:8], pixel: m_tdata[47:16], last: m_tlast};
                if (pending_words.size() == 0) begin
                    $error("word %0d: result with nothing expected (tdata 0x%0h)",
                           results_seen, m_tdata);
                    fail_cnt++;
                end else begin
                    want_w = pending_words.pop_front();
                    check_field("is_length_code", want_w.is_code, got_w.is_code);
                    check_field("is_row_end", want_w.row_end, got_w.row_end);
                    check_field("empty_count", want_w.empty, got_w.empty);
                    check_field("filled_count", want_w.filled, got_w.filled);
                    check_field("pixel_out", want_w.pixel, got_w.pixel);
                    check_field("last_of_burst", want_w.last, got_w.last);
                    if (want_w.is_code) codes_seen++;
                    else literals_seen++;
                    if (want_w.row_end) end_codes_seen++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, pending_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        rle_word_t known_w;
        int        dir_words;
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        s_tlast            = 1'b0;
        m_tready           = 1'b0;
        quiet              = 1'b0;
        hold_req           = 1'b0;
        hold_left          = 0;
        stall_left         = 0;
        cycle_cnt          = 0;
        fail_cnt           = 0;
        words_sent         = 0;
        results_seen       = 0;
        codes_seen         = 0;
        end_codes_seen     = 0;
        literals_seen      = 0;
        longest_burst      = 0;
        input_stall_cycles = 0;
        enc_filled_phase   = 1'b0;
        enc_empty_run      = 8'd0;
        enc_filled_run     = 8'd0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; pixels step through the repeat so literals differ
        foreach (DIRECTED[r]) begin
            known_w = code_word(DIRECTED[r].k_empty, 8'd0, DIRECTED[r].k_end);
            known_w.last = 1'b1;
            for (int j = 0; j < DIRECTED[r].rep; j++) begin
                drive_word(DIRECTED[r].pix + j * 32'h0102_0409, DIRECTED[r].transp,
                           DIRECTED[r].rend && j == DIRECTED[r].rep - 1,
                           DIRECTED[r].known && j == DIRECTED[r].rep - 1, known_w);
            end
        end
        dir_words = words_sent;

        // sender pauses until the encoder has emptied out
        wait_drained();

        // long receiver hold while the sender keeps offering words
        hold_req <= 1'b1;
        while (words_sent - dir_words < RANDOM_WORDS) begin
            if (words_sent - dir_words >= RANDOM_WORDS * 3 / 4)
                quiet <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                drive_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'b0, '0);
            else
                send_random_row();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d pixel words (%0d directed), checked %0d result words",
                 words_sent, dir_words, results_seen);
        $display("codes %0d (row-end %0d), literals %0d, longest burst %0d, input stalls %0d",
                 codes_seen, end_codes_seen, literals_seen, longest_burst,
                 input_stall_cycles);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
